// ===== hdl/complex_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared concurrent assertion forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Sizes, operation codes and the item type shared by the block's modules.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int FRAC_BITS    = 16;
   localparam int IN_BITS      = 16;
   localparam int RES_BITS     = 48;

   // internal widths
   localparam int PROD_BITS  = 2 * OPERAND_BITS;
   localparam int VAL_BITS   = 2 * OPERAND_BITS + 2;
   localparam int MAG_BITS   = 2 * OPERAND_BITS + 1;
   localparam int DEN_BITS   = 2 * OPERAND_BITS + 1;
   localparam int NUM_BITS   = MAG_BITS + FRAC_BITS;
   localparam int Q_BITS     = (NUM_BITS > RES_BITS) ? NUM_BITS : RES_BITS;
   localparam int DIV_STAGES = NUM_BITS;

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // saturation limits
   localparam logic signed [63:0] RES_MAX = (64'sd1 <<< (RES_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] RES_MIN = -RES_MAX - 64'sd1;
   localparam logic signed [63:0] SAT_HI  = RES_MAX >>> FRAC_BITS;
   localparam logic signed [63:0] SAT_LO  = -((64'sd1 <<< (RES_BITS - 1)) >>> FRAC_BITS);

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                        kind;
      logic                            dz;
      logic signed [OPERAND_BITS-1:0]  a_re;
      logic signed [OPERAND_BITS-1:0]  a_im;
      logic signed [OPERAND_BITS-1:0]  b_re;
      logic signed [OPERAND_BITS-1:0]  b_im;
   } item_type;

endpackage

// ===== hdl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Complex add, subtract, multiply and divide of integer operands, fixed-point
// results with 16 fraction bits, saturated to 48 bits.
//
// Usage:
//  - request side is a queue: drive req_kind and the four operand parts and
//    raise req_push; a beat is taken on a clock edge with req_push high and
//    req_full low
//  - result side is a queue: rsp_res_re, rsp_res_im and rsp_div_by_zero hold
//    the oldest result while rsp_empty is low; rsp_pop takes it
//  - a divide by zero returns zero parts with rsp_div_by_zero set
//  - throughput is one beat per cycle for every operation unless the result
//    side stalls; every beat takes the same path through the product stages
//    and the 49-stage quotient pipeline (one quotient bit per stage), so
//    results keep request order
//  - an accepted beat passes the front register (loaded on the accepting
//    edge), the queue write, two product stages, quotient entry, 49 quotient
//    stages and the result register, and then rsp_empty goes low
//  - when the result side stalls the datapath freezes; the front register
//    and a four-entry queue keep absorbing requests until full rises
//  - synchronous reset empties both queues and the pipeline; no clearing pass
// ----------------------------------------------------------------------------
module complex_arith_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_kind,
   input  logic signed [cau_pkg::IN_BITS-1:0]  req_a_re,
   input  logic signed [cau_pkg::IN_BITS-1:0]  req_a_im,
   input  logic signed [cau_pkg::IN_BITS-1:0]  req_b_re,
   input  logic signed [cau_pkg::IN_BITS-1:0]  req_b_im,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [cau_pkg::RES_BITS-1:0] rsp_res_re,
   output logic signed [cau_pkg::RES_BITS-1:0] rsp_res_im,
   output logic                                rsp_div_by_zero
);

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   cau_pkg::item_type q_in_item;
   cau_pkg::item_type q_out_item;

   // request intake and classification
   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_kind (req_kind),
      .req_a_re (req_a_re),
      .req_a_im (req_a_im),
      .req_b_re (req_b_re),
      .req_b_im (req_b_im),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_item   (q_in_item)
   );

   // decoupling queue
   cau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_item (q_in_item),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_out_item)
   );

   // arithmetic datapath and result register
   cau_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_item          (q_out_item),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_res_re      (rsp_res_re),
      .rsp_res_im      (rsp_res_im),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

endmodule

// ===== hdl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts request beats, trims operands and flags zero-divisor divides.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [1:0]              req_kind,
   input  logic [cau_pkg::IN_BITS-1:0] req_a_re,
   input  logic [cau_pkg::IN_BITS-1:0] req_a_im,
   input  logic [cau_pkg::IN_BITS-1:0] req_b_re,
   input  logic [cau_pkg::IN_BITS-1:0] req_b_im,
   output logic                    q_push,
   input  logic                    q_full,
   output cau_pkg::item_type       q_item
);

   logic               valid_ff;
   logic               valid_in;
   cau_pkg::item_type  item_ff;
   cau_pkg::item_type  item_in;
   logic               take;

   // operand field trimmed to operand width, sign taken from its top bit
   function automatic logic signed [cau_pkg::OPERAND_BITS-1:0] trim(
      input logic [cau_pkg::IN_BITS-1:0] f);
      logic [cau_pkg::IN_BITS+cau_pkg::OPERAND_BITS-1:0] ext;
      ext  = {{cau_pkg::OPERAND_BITS{1'b0}}, f};
      trim = ext[cau_pkg::OPERAND_BITS-1:0];
   endfunction

   // stage is free when empty or draining into the queue
   assign take     = !valid_ff || !q_full;
   assign req_full = !take;
   assign q_push   = valid_ff && !q_full;
   assign q_item   = item_ff;

   // classify the beat
   always_comb begin
      item_in.kind = cau_pkg::kind_type'(req_kind);
      item_in.a_re = trim(req_a_re);
      item_in.a_im = trim(req_a_im);
      item_in.b_re = trim(req_b_re);
      item_in.b_im = trim(req_b_im);
      item_in.dz   = (item_in.kind == cau_pkg::KIND_DIV) &&
                     (item_in.b_re == '0) && (item_in.b_im == '0);
      valid_in     = take ? req_push : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take && req_push) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hdl/cau_queue.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit decoupling queue
// Short first-in first-out store between the front end and the datapath.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_macros.svh"

module cau_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cau_pkg::item_type push_item,
   input  logic              pop,
   output logic              empty,
   output cau_pkg::item_type pop_item
);

   cau_pkg::item_type                mem_ff [cau_pkg::QUEUE_DEPTH];
   logic [cau_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cau_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cau_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             push_en;
   logic                             pop_en;

   assign full     = (count_ff == cau_pkg::QCNT_BITS'(cau_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign push_en  = push && !full;
   assign pop_en   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + 1'b1;
      end else if (!push_en && pop_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CAU_ASSERT_NEXT(a_fill_up, clock, reset, push_en && !pop_en, count_ff == $past(count_ff) + 1'b1, "queue fill count did not rise on a lone push")
   `CAU_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, count_ff <= cau_pkg::QCNT_BITS'(cau_pkg::QUEUE_DEPTH), "queue fill count beyond depth")

endmodule

// ===== hdl/cau_back.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit datapath
// Products, sums and a one-bit-per-stage quotient pipeline with saturation.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_macros.svh"

module cau_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   output logic                                q_pop,
   input  cau_pkg::item_type                   q_item,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [cau_pkg::RES_BITS-1:0] rsp_res_re,
   output logic signed [cau_pkg::RES_BITS-1:0] rsp_res_im,
   output logic                                rsp_div_by_zero
);

   localparam int OB = cau_pkg::OPERAND_BITS;
   localparam int PB = cau_pkg::PROD_BITS;
   localparam int VB = cau_pkg::VAL_BITS;
   localparam int DB = cau_pkg::DEN_BITS;
   localparam int NB = cau_pkg::NUM_BITS;
   localparam int QB = cau_pkg::Q_BITS;
   localparam int RB = cau_pkg::RES_BITS;
   localparam int NS = cau_pkg::DIV_STAGES;

   localparam logic [QB:0] Q_HALF = (QB+1)'(1) << (RB - 1);
   localparam logic [QB:0] Q_MAX  = Q_HALF - 1'b1;

   logic adv;

   // stage 1: products and sums
   logic                 s1_v_ff;
   cau_pkg::kind_type    s1_kind_ff;
   logic                 s1_dz_ff;
   logic signed [PB-1:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_bb_ff, s1_cc_ff;
   logic signed [OB:0]   s1_sr_ff, s1_si_ff;

   // stage 2: combined values and divisor
   logic                 s2_v_ff;
   cau_pkg::kind_type    s2_kind_ff;
   logic                 s2_dz_ff;
   logic signed [VB-1:0] s2_re_ff, s2_im_ff;
   logic [DB-1:0]        s2_den_ff;

   // quotient pipeline, place 0 is the entry stage
   logic          d_v_ff   [NS+1];
   logic          d_div_ff [NS+1];
   logic          d_dz_ff  [NS+1];
   logic          d_nre_ff [NS+1];
   logic          d_nim_ff [NS+1];
   logic [DB-1:0] d_den_ff [NS+1];
   logic [DB-1:0] d_rre_ff [NS+1];
   logic [DB-1:0] d_rim_ff [NS+1];
   logic [QB-1:0] d_qre_ff [NS+1];
   logic [QB-1:0] d_qim_ff [NS+1];

   // result register
   logic                 out_v_ff;
   logic signed [RB-1:0] out_re_ff;
   logic signed [RB-1:0] out_im_ff;
   logic                 out_dz_ff;

   // integer value scaled to fixed point, clamped to the result range
   function automatic logic [QB-1:0] scale_sat(input logic signed [VB-1:0] v);
      logic signed [63:0] w;
      logic signed [63:0] s;
      w = 64'(v);
      if (w > cau_pkg::SAT_HI) begin
         s = cau_pkg::RES_MAX;
      end else if (w < cau_pkg::SAT_LO) begin
         s = cau_pkg::RES_MIN;
      end else begin
         s = w <<< cau_pkg::FRAC_BITS;
      end
      scale_sat = QB'(s[RB-1:0]);
   endfunction

   // magnitude of a numerator, placed above the fraction bits
   function automatic logic [QB-1:0] num_init(input logic signed [VB-1:0] v);
      logic [VB-1:0] m;
      m        = v[VB-1] ? VB'(-v) : VB'(v);
      num_init = QB'(m[cau_pkg::MAG_BITS-1:0]) << cau_pkg::FRAC_BITS;
   endfunction

   // one restoring division step: remainder and shifting dividend/quotient
   function automatic logic [DB+QB-1:0] div_step(input logic [DB-1:0] rem,
                                                   input logic [QB-1:0] n,
                                                   input logic [DB-1:0] den);
      logic [DB:0]   t;
      logic          ge;
      logic [DB-1:0] r;
      t        = {rem, n[NB-1]};
      ge       = (t >= {1'b0, den});
      r        = ge ? DB'(t - {1'b0, den}) : t[DB-1:0];
      div_step = {r, QB'({n[NB-2:0], ge})};
   endfunction

   // final clamp of a signed quotient
   function automatic logic [RB-1:0] quo_sat(input logic neg, input logic [QB-1:0] q);
      logic [QB:0] w;
      w = {1'b0, q};
      if (neg) begin
         quo_sat = (w >= Q_HALF) ? RB'(cau_pkg::RES_MIN) : RB'(-w);
      end else begin
         quo_sat = (w > Q_MAX) ? RB'(cau_pkg::RES_MAX) : w[RB-1:0];
      end
   endfunction

   // whole pipeline moves when the result register is free or being read
   assign adv   = !out_v_ff || rsp_pop;
   assign q_pop = adv && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            d_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff  <= q_pop;
         s2_v_ff  <= s1_v_ff;
         d_v_ff[0] <= s2_v_ff;
         for (int k = 1; k <= NS; k++) begin
            d_v_ff[k] <= d_v_ff[k-1];
         end
         out_v_ff <= d_v_ff[NS];
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // products and sums
         s1_kind_ff <= q_item.kind;
         s1_dz_ff   <= q_item.dz;
         s1_rr_ff   <= q_item.a_re * q_item.b_re;
         s1_ii_ff   <= q_item.a_im * q_item.b_im;
         s1_ri_ff   <= q_item.a_re * q_item.b_im;
         s1_ir_ff   <= q_item.a_im * q_item.b_re;
         s1_bb_ff   <= q_item.b_re * q_item.b_re;
         s1_cc_ff   <= q_item.b_im * q_item.b_im;
         if (q_item.kind == cau_pkg::KIND_SUB) begin
            s1_sr_ff <= (OB+1)'(q_item.a_re) - (OB+1)'(q_item.b_re);
            s1_si_ff <= (OB+1)'(q_item.a_im) - (OB+1)'(q_item.b_im);
         end else begin
            s1_sr_ff <= (OB+1)'(q_item.a_re) + (OB+1)'(q_item.b_re);
            s1_si_ff <= (OB+1)'(q_item.a_im) + (OB+1)'(q_item.b_im);
         end

         // combine per operation
         s2_kind_ff <= s1_kind_ff;
         s2_dz_ff   <= s1_dz_ff;
         s2_den_ff  <= DB'(s1_bb_ff) + DB'(s1_cc_ff);
         case (s1_kind_ff)
            cau_pkg::KIND_MUL: begin
               s2_re_ff <= VB'(s1_rr_ff) - VB'(s1_ii_ff);
               s2_im_ff <= VB'(s1_ri_ff) + VB'(s1_ir_ff);
            end
            cau_pkg::KIND_DIV: begin
               s2_re_ff <= VB'(s1_rr_ff) + VB'(s1_ii_ff);
               s2_im_ff <= VB'(s1_ir_ff) - VB'(s1_ri_ff);
            end
            default: begin
               s2_re_ff <= VB'(s1_sr_ff);
               s2_im_ff <= VB'(s1_si_ff);
            end
         endcase

         // quotient entry, other operations finish here
         d_div_ff[0] <= (s2_kind_ff == cau_pkg::KIND_DIV) && !s2_dz_ff;
         d_dz_ff[0]  <= s2_dz_ff;
         d_nre_ff[0] <= s2_re_ff[VB-1];
         d_nim_ff[0] <= s2_im_ff[VB-1];
         d_den_ff[0] <= s2_den_ff;
         d_rre_ff[0] <= '0;
         d_rim_ff[0] <= '0;
         if (s2_dz_ff) begin
            d_qre_ff[0] <= '0;
            d_qim_ff[0] <= '0;
         end else if (s2_kind_ff == cau_pkg::KIND_DIV) begin
            d_qre_ff[0] <= num_init(s2_re_ff);
            d_qim_ff[0] <= num_init(s2_im_ff);
         end else begin
            d_qre_ff[0] <= scale_sat(s2_re_ff);
            d_qim_ff[0] <= scale_sat(s2_im_ff);
         end

         // one quotient bit per stage
         for (int k = 1; k <= NS; k++) begin
            d_div_ff[k] <= d_div_ff[k-1];
            d_dz_ff[k]  <= d_dz_ff[k-1];
            d_nre_ff[k] <= d_nre_ff[k-1];
            d_nim_ff[k] <= d_nim_ff[k-1];
            d_den_ff[k] <= d_den_ff[k-1];
            if (d_div_ff[k-1]) begin
               {d_rre_ff[k], d_qre_ff[k]} <= div_step(d_rre_ff[k-1], d_qre_ff[k-1],
                                                      d_den_ff[k-1]);
               {d_rim_ff[k], d_qim_ff[k]} <= div_step(d_rim_ff[k-1], d_qim_ff[k-1],
                                                      d_den_ff[k-1]);
            end else begin
               d_rre_ff[k] <= d_rre_ff[k-1];
               d_rim_ff[k] <= d_rim_ff[k-1];
               d_qre_ff[k] <= d_qre_ff[k-1];
               d_qim_ff[k] <= d_qim_ff[k-1];
            end
         end

         // result register with quotient sign and clamp
         out_dz_ff <= d_dz_ff[NS];
         if (d_div_ff[NS]) begin
            out_re_ff <= quo_sat(d_nre_ff[NS], d_qre_ff[NS]);
            out_im_ff <= quo_sat(d_nim_ff[NS], d_qim_ff[NS]);
         end else begin
            out_re_ff <= d_qre_ff[NS][RB-1:0];
            out_im_ff <= d_qim_ff[NS][RB-1:0];
         end
      end
   end

   assign rsp_empty       = !out_v_ff;
   assign rsp_res_re      = out_re_ff;
   assign rsp_res_im      = out_im_ff;
   assign rsp_div_by_zero = out_dz_ff;

   `CAU_ASSERT_NOW(a_dz_zero, clock, reset, out_v_ff && out_dz_ff, out_re_ff == '0 && out_im_ff == '0, "zero-divisor result with nonzero parts")
   `CAU_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, out_v_ff && d_v_ff[NS] == $past(d_v_ff[NS]), "pipeline moved while the result was stalled")

endmodule

// ===== sim/complex_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operand beats through the request queue under several idle patterns,
// predicts each complex sum, difference, product or quotient in exact
// integer arithmetic and checks every result beat in order.
// ----------------------------------------------------------------------------

// expected-result store and comparison
class cau_scoreboard;
   typedef struct {
      longint re;
      longint im;
      logic   dz;
   } cplx_result;

   cplx_result pending[$];
   int         mismatches;

   // exact integer scaled by 2^16, clamped to 48 bits
   function automatic longint scale_clamp(longint v);
      longint hi_lim;
      hi_lim = (64'sd1 <<< 31) - 1;
      if (v > hi_lim) return (64'sd1 <<< 47) - 1;
      if (v < -(64'sd1 <<< 31)) return -(64'sd1 <<< 47);
      return v <<< 16;
   endfunction

   // num * 2^16 / den, toward zero, clamped; den > 0
   function automatic longint quotient_clamp(longint num, longint den);
      logic [127:0] mag;
      logic [127:0] q;
      logic         neg;
      neg = num < 0;
      mag = neg ? 128'(-num) : 128'(num);
      q = (mag << 16) / 128'(den);
      if (!neg && q > 128'((64'sd1 <<< 47) - 1)) return (64'sd1 <<< 47) - 1;
      if (neg && q >= 128'(64'sd1 <<< 47)) return -(64'sd1 <<< 47);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // work out the expected result of one accepted request beat
   function void note_request(cau_pkg::kind_type kind, logic signed [15:0] ar,
                              logic signed [15:0] ai, logic signed [15:0] br,
                              logic signed [15:0] bi);
      cplx_result r;
      longint     xr, xi, yr, yi, den;
      xr = ar; xi = ai; yr = br; yi = bi;
      r.dz = 1'b0;
      r.re = 0;
      r.im = 0;
      case (kind)
         cau_pkg::KIND_ADD: begin
            r.re = scale_clamp(xr + yr);
            r.im = scale_clamp(xi + yi);
         end
         cau_pkg::KIND_SUB: begin
            r.re = scale_clamp(xr - yr);
            r.im = scale_clamp(xi - yi);
         end
         cau_pkg::KIND_MUL: begin
            r.re = scale_clamp(xr * yr - xi * yi);
            r.im = scale_clamp(xr * yi + xi * yr);
         end
         default: begin
            den = yr * yr + yi * yi;
            if (den == 0) r.dz = 1'b1;
            else begin
               r.re = quotient_clamp(xr * yr + xi * yi, den);
               r.im = quotient_clamp(xi * yr - xr * yi, den);
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   // compare one result beat with the oldest expectation
   function void check_result(logic signed [47:0] re, logic signed [47:0] im,
                              logic dz);
      cplx_result e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat re=%0d im=%0d", re, im);
         return;
      end
      e = pending.pop_front();
      if (re !== e.re || im !== e.im || dz !== e.dz) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                     e.re, e.im, e.dz, re, im, dz);
      end
   endfunction
endclass

module complex_arith_unit_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_kind = '0;
   logic signed [15:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [47:0] rsp_res_re, rsp_res_im;
   logic               rsp_div_by_zero;

   cau_scoreboard results = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  idle_count = 0;

   complex_arith_unit dut (.*);

   always #5 clock = ~clock;

   // result side: random stalls, check each popped beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            results.check_result(rsp_res_re, rsp_res_im, rsp_div_by_zero);
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_count <= 0;
      else if (!reset) idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("complex_arith_unit test failed");
         $finish;
      end
   end

   // one request beat, held until taken; push stays high into the next beat
   task automatic send_request(cau_pkg::kind_type k, logic [15:0] ar, logic [15:0] ai,
                               logic [15:0] br, logic [15:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= k;
      req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      do @(posedge clock); while (req_full);
      results.note_request(k, ar, ai, br, bi);
   endtask

   function automatic logic [15:0] rand_part();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_requests(int count);
      logic [15:0] br, bi;
      repeat (count) begin
         br = rand_part();
         bi = ($urandom_range(9) == 0) ? 16'h0000 : rand_part();
         send_request(cau_pkg::kind_type'($urandom_range(3)), rand_part(), rand_part(),
                      br, bi);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, saturation, zero divisor
      send_request(cau_pkg::KIND_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_request(cau_pkg::KIND_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_request(cau_pkg::KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
      send_request(cau_pkg::KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(cau_pkg::KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
      send_request(cau_pkg::KIND_MUL, 16'hffff, 16'h0001, 16'h0002, 16'hfffd);
      send_request(cau_pkg::KIND_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
      send_request(cau_pkg::KIND_ADD, 16'h0001, 16'h0002, 16'h0000, 16'h0000);
      send_request(cau_pkg::KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      send_request(cau_pkg::KIND_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
      send_request(cau_pkg::KIND_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
      send_request(cau_pkg::KIND_DIV, 16'h0007, 16'hfffd, 16'h0003, 16'h0002);
      send_request(cau_pkg::KIND_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(cau_pkg::KIND_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

      // random phases with different idle patterns
      random_requests(180);
      send_idle_pct = 88;
      random_requests(120);
      send_idle_pct = 0; recv_stall_pct = 88;
      random_requests(160);
      send_idle_pct = 12; recv_stall_pct = 12;
      random_requests(180);
      req_push <= 1'b0;

      while (results.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (results.mismatches == 0 && results.pending.size() == 0)
         $display("complex_arith_unit test passed");
      else
         $display("complex_arith_unit test failed");
      $finish;
   end
endmodule
